>>> sv/platform_interrupt_controller_assert.svh
// assertion macros for the interrupt controller checker
`ifndef PLATFORM_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define PIC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pic assertion failed");

// antecedent implies consequent in the same cycle
`define PIC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pic assertion failed");

`endif

>>> sv/pic_pkg.sv
// package with types, constants and helpers of the interrupt controller
package pic_pkg;

    localparam int SOURCES      = 32;
    localparam int HARTS        = 1;
    localparam int PRIORITY_MAX = 7;

    localparam int PRIO_W = $clog2(PRIORITY_MAX + 1);
    localparam int ID_W   = $clog2(SOURCES);

    localparam logic [SOURCES-1:0] VALID_MASK = {{(SOURCES-1){1'b1}}, 1'b0};

    localparam logic [21:0] ADDR_PENDING   = 22'h001000;
    localparam logic [21:0] ADDR_ENABLE    = 22'h002000;
    localparam logic [11:0] CTX_THRESHOLD  = 12'h000;
    localparam logic [11:0] CTX_CLAIM      = 12'h004;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_SPARE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [21:0] address;
        logic [31:0] write_data;
        logic [31:0] source_levels;
    } req_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        hart_irq;
    } rsp_item_t;

    typedef logic [SOURCES-1:0][PRIO_W-1:0] prio_array_t;

    function automatic logic [PRIO_W-1:0] clamp_prio(input logic [31:0] v);
        if (v > 32'(PRIORITY_MAX))
            return PRIO_W'(PRIORITY_MAX);
        else
            return v[PRIO_W-1:0];
    endfunction

    // highest priority above threshold, lowest id on ties, 0 when none
    function automatic logic [ID_W-1:0] best_id(
        input logic [SOURCES-1:0] cand,
        input prio_array_t        prio,
        input logic [PRIO_W-1:0]  thr
    );
        logic [SOURCES-1:0]    elig;
        logic [PRIORITY_MAX:0] hit;
        logic [PRIO_W-1:0]     top;
        logic [ID_W-1:0]       id;
        elig = '0;
        hit  = '0;
        top  = '0;
        id   = '0;
        for (int i = 0; i < SOURCES; i++)
        begin
            elig[i] = cand[i] && (prio[i] > thr);
        end
        for (int p = 1; p <= PRIORITY_MAX; p++)
        begin
            for (int i = 0; i < SOURCES; i++)
            begin
                if (elig[i] && (prio[i] == PRIO_W'(p)))
                    hit[p] = 1'b1;
            end
        end
        for (int p = 1; p <= PRIORITY_MAX; p++)
        begin
            if (hit[p])
                top = PRIO_W'(p);
        end
        for (int i = SOURCES - 1; i >= 1; i--)
        begin
            if (elig[i] && (prio[i] == top))
                id = ID_W'(i);
        end
        return id;
    endfunction

endpackage

>>> sv/platform_interrupt_controller.sv
// top level of the platform interrupt controller
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------
//  request   | start in, busy out   | kind, address, data, levels
//  response  | done out (strobe)    | read_data, hart_irq
//
// one transaction per cycle; busy never rises
// a taken request is held in the request registers and its response in the result registers
// claim search and register decode sit between the request and result registers
// asynchronous reset clears all priorities, enables, thresholds, pending and in-service bits
// the receiver cannot stall: each response is shown for exactly one cycle
module platform_interrupt_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pic_pkg::req_item_t  request,
    output logic                done,
    output pic_pkg::rsp_item_t  response
);
    import pic_pkg::*;

    logic        in_valid_reg;
    req_item_t   in_item_reg;
    logic        out_valid_reg;
    rsp_item_t   out_item_reg;

    prio_array_t                          prio_reg, prio_next;
    logic [SOURCES-1:0]                   pending_reg, pending_next;
    logic [SOURCES-1:0]                   in_service_reg, in_service_next;
    logic [HARTS-1:0][SOURCES-1:0]        enable_reg, enable_next;
    logic [HARTS-1:0][PRIO_W-1:0]         threshold_reg, threshold_next;

    rsp_item_t           rsp_next;
    logic                is_rd, is_wr, aligned;
    logic [21:0]         addr;
    logic [SOURCES-1:0]  pend_s;
    logic [20:0]         en_off;
    logic                in_prio, in_pend, in_en, in_ctx;
    logic [SOURCES-1:0]  en_ctx;
    logic [PRIO_W-1:0]   thr_ctx;
    logic                ctx_hit;
    logic [ID_W-1:0]     claim_id;
    logic [SOURCES-1:0]  done_bit;
    logic [SOURCES-1:0]  gt0;

    assign busy     = 1'b0;
    assign done     = out_valid_reg;
    assign response = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prio_reg       <= '0;
            pending_reg    <= '0;
            in_service_reg <= '0;
            enable_reg     <= '0;
            threshold_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                prio_reg       <= prio_next;
                pending_reg    <= pending_next;
                in_service_reg <= in_service_next;
                enable_reg     <= enable_next;
                threshold_reg  <= threshold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_item_reg <= request;
        if (in_valid_reg)
            out_item_reg <= rsp_next;
    end

    always_comb
    begin
        addr    = in_item_reg.address;
        is_rd   = (in_item_reg.kind == KIND_READ);
        is_wr   = (in_item_reg.kind == KIND_WRITE);
        aligned = (addr[1:0] == 2'b00);

        // sample the source lines first
        pend_s = pending_reg
               | (in_item_reg.source_levels[SOURCES-1:0] & ~in_service_reg & VALID_MASK);

        in_prio = aligned && (addr[21:12] == 10'd0);
        in_pend = aligned && (addr == ADDR_PENDING);
        in_en   = aligned && !addr[21] && (addr >= ADDR_ENABLE);
        in_ctx  = aligned && addr[21];
        en_off  = addr[20:0] - ADDR_ENABLE[20:0];

        en_ctx  = '0;
        thr_ctx = '0;
        ctx_hit = 1'b0;
        for (int h = 0; h < HARTS; h++)
        begin
            if (addr[20:12] == 9'(h))
            begin
                en_ctx  = enable_reg[h];
                thr_ctx = threshold_reg[h];
                ctx_hit = in_ctx;
            end
        end

        prio_next       = prio_reg;
        pending_next    = pend_s;
        in_service_next = in_service_reg;
        enable_next     = enable_reg;
        threshold_next  = threshold_reg;
        rsp_next        = '0;

        claim_id = best_id(pend_s & en_ctx & VALID_MASK, prio_reg, thr_ctx);
        done_bit = SOURCES'(1) << in_item_reg.write_data[ID_W-1:0];

        if (in_prio && (addr[11:2] < 10'(SOURCES)) && (addr[11:2] != 10'd0))
        begin
            if (is_rd)
                rsp_next.read_data = 32'(prio_reg[addr[ID_W+1:2]]);
            for (int i = 1; i < SOURCES; i++)
            begin
                if (is_wr && (addr[11:2] == 10'(i)))
                    prio_next[i] = clamp_prio(in_item_reg.write_data);
            end
        end

        if (in_pend && is_rd)
            rsp_next.read_data = 32'(pend_s);

        if (in_en && (en_off[6:0] == 7'd0))
        begin
            for (int h = 0; h < HARTS; h++)
            begin
                if (en_off[20:7] == 14'(h))
                begin
                    if (is_rd)
                        rsp_next.read_data = 32'(enable_reg[h]);
                    if (is_wr)
                        enable_next[h] = in_item_reg.write_data[SOURCES-1:0] & VALID_MASK;
                end
            end
        end

        if (ctx_hit && (addr[11:0] == CTX_THRESHOLD))
        begin
            if (is_rd)
                rsp_next.read_data = 32'(thr_ctx);
            for (int h = 0; h < HARTS; h++)
            begin
                if (is_wr && (addr[20:12] == 9'(h)))
                    threshold_next[h] = clamp_prio(in_item_reg.write_data);
            end
        end

        if (ctx_hit && (addr[11:0] == CTX_CLAIM))
        begin
            if (is_rd)
            begin
                rsp_next.read_data = 32'(claim_id);
                if (claim_id != '0)
                begin
                    pending_next[claim_id]    = 1'b0;
                    in_service_next[claim_id] = 1'b1;
                end
            end
            else if (is_wr && (in_item_reg.write_data < 32'(SOURCES)))
            begin
                if ((done_bit & VALID_MASK & in_service_reg & en_ctx) != '0)
                    in_service_next = in_service_reg & ~done_bit;
            end
        end

        // interrupt line of hart 0 from the updated state
        for (int i = 0; i < SOURCES; i++)
        begin
            gt0[i] = prio_next[i] > threshold_next[0];
        end
        rsp_next.hart_irq = |(pending_next & enable_next[0] & VALID_MASK & gt0);
    end

endmodule

>>> sv/pic_checker.sv
// port checker for the interrupt controller, bound to the top level
`include "platform_interrupt_controller_assert.svh"

module pic_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input pic_pkg::req_item_t  request,
    input logic                done,
    input pic_pkg::rsp_item_t  response
);
    import pic_pkg::*;

    logic        took_1_reg;
    logic        took_2_reg;
    logic        rd_1_reg;
    logic        rd_2_reg;
    logic [21:0] addr_1_reg;
    logic [21:0] addr_2_reg;

    logic took_2;
    logic rd_2;
    logic [21:0] addr_2;

    // request history, registered through the _1 and then the _2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            took_1_reg <= 1'b0;
            took_2_reg <= 1'b0;
            rd_1_reg   <= 1'b0;
            rd_2_reg   <= 1'b0;
            addr_1_reg <= '0;
            addr_2_reg <= '0;
        end
        else
        begin
            took_1_reg <= start && !busy;
            took_2_reg <= took_1_reg;
            rd_1_reg   <= (request.kind == KIND_READ);
            rd_2_reg   <= rd_1_reg;
            addr_1_reg <= request.address;
            addr_2_reg <= addr_1_reg;
        end
    end

    assign took_2 = took_2_reg;
    assign rd_2   = rd_2_reg;
    assign addr_2 = addr_2_reg;

    `PIC_ASSERT_ALWAYS(a_latency, clk, rst_n, done == took_2)
    `PIC_ASSERT_IMPLIES(a_no_read_zero, clk, rst_n, done && !rd_2, response.read_data == 32'd0)
    `PIC_ASSERT_IMPLIES(a_claim_range, clk, rst_n,
        done && rd_2 && (addr_2 == 22'h200004), response.read_data < 32'(SOURCES))
    `PIC_ASSERT_IMPLIES(a_prio_range, clk, rst_n,
        done && rd_2 && (addr_2 < 22'h001000), response.read_data <= 32'(PRIORITY_MAX))

endmodule

bind platform_interrupt_controller pic_checker u_pic_checker (.*);

>>> dv/platform_interrupt_controller_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the platform interrupt controller with its own predictor
module platform_interrupt_controller_tb;

    import pic_pkg::*;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          PHASE_ITEMS    = 325;
    localparam int          MISMATCH_SHOWN = 10;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [21:0] ADDR_PRIORITY  = 22'h000000;
    localparam logic [21:0] ADDR_CONTEXT   = 22'h200000;
    localparam logic [21:0] ADDR_THRESHOLD = ADDR_CONTEXT | 22'(CTX_THRESHOLD);
    localparam logic [21:0] ADDR_CLAIM     = ADDR_CONTEXT | 22'(CTX_CLAIM);
    localparam logic [21:0] ENABLE_STRIDE  = 22'h000080;
    localparam logic [21:0] CONTEXT_STRIDE = 22'h001000;

    typedef struct {
        req_item_t item;
        bit        fixed;
        rsp_item_t want;
    } directed_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    req_item_t request;
    logic      done;
    rsp_item_t response;

    logic [2:0]  prio_table [SOURCES];
    logic [31:0] pending_set;
    logic [31:0] service_set;
    logic [31:0] enable_set;
    logic [2:0]  threshold_level;

    rsp_item_t     expected_responses [$];
    directed_row_t directed_rows [$];
    int            mismatch_count;
    int            cycle_count;
    int            idle_pct [4] = '{0, 88, 0, 36};

    platform_interrupt_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [2:0] saturate_level(input logic [31:0] value);
        return (value > 32'(PRIORITY_MAX)) ? 3'(PRIORITY_MAX) : value[2:0];
    endfunction

    // highest priority above threshold wins, lowest id on ties
    function automatic logic [4:0] winning_source();
        logic [31:0] eligible;
        logic [2:0]  top;
        logic [4:0]  winner;
        eligible = pending_set & enable_set & VALID_MASK;
        top      = threshold_level;
        winner   = '0;
        for (int id = 1; id < SOURCES; id++)
        begin
            if (eligible[id] && prio_table[id] > top)
            begin
                top    = prio_table[id];
                winner = 5'(id);
            end
        end
        return winner;
    endfunction

    function automatic rsp_item_t predict_response(input req_item_t item);
        rsp_item_t   rsp;
        logic [21:0] offset;
        logic [4:0]  claimed;
        logic [31:0] bit_mask;
        rsp = '0;
        pending_set = pending_set | (item.source_levels & ~service_set & VALID_MASK);
        if ((item.kind == KIND_READ || item.kind == KIND_WRITE) && item.address[1:0] == 2'b00)
        begin
            if (item.address < ADDR_PENDING)
            begin
                offset = item.address >> 2;
                if (offset < 22'(SOURCES) && offset != 0)
                begin
                    if (item.kind == KIND_READ)
                        rsp.read_data = 32'(prio_table[offset]);
                    else
                        prio_table[offset] = saturate_level(item.write_data);
                end
            end
            else if (item.address == ADDR_PENDING)
            begin
                if (item.kind == KIND_READ)
                    rsp.read_data = pending_set;
            end
            else if (item.address >= ADDR_ENABLE && item.address < ADDR_CONTEXT)
            begin
                offset = item.address - ADDR_ENABLE;
                if (offset < ENABLE_STRIDE * 22'(HARTS) && offset[6:0] == 7'd0)
                begin
                    if (item.kind == KIND_READ)
                        rsp.read_data = enable_set;
                    else
                        enable_set = item.write_data & VALID_MASK;
                end
            end
            else if (item.address >= ADDR_CONTEXT)
            begin
                offset = item.address - ADDR_CONTEXT;
                if (offset < CONTEXT_STRIDE * 22'(HARTS))
                begin
                    if (offset[11:0] == CTX_THRESHOLD)
                    begin
                        if (item.kind == KIND_READ)
                            rsp.read_data = 32'(threshold_level);
                        else
                            threshold_level = saturate_level(item.write_data);
                    end
                    else if (offset[11:0] == CTX_CLAIM)
                    begin
                        if (item.kind == KIND_READ)
                        begin
                            claimed = winning_source();
                            if (claimed != 0)
                            begin
                                pending_set[claimed] = 1'b0;
                                service_set[claimed] = 1'b1;
                            end
                            rsp.read_data = 32'(claimed);
                        end
                        else if (item.write_data < 32'(SOURCES))
                        begin
                            bit_mask = 32'd1 << item.write_data[4:0];
                            if ((bit_mask & VALID_MASK & service_set & enable_set) != 0)
                                service_set = service_set & ~bit_mask;
                        end
                    end
                end
            end
        end
        rsp.hart_irq = (winning_source() != 0);
        return rsp;
    endfunction

    function automatic logic [31:0] completion_id();
        int          first;
        logic [31:0] id;
        id = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40));
        if ($urandom_range(3) != 0 && service_set != 0)
        begin
            first = $urandom_range(SOURCES - 1, 1);
            for (int i = 0; i < SOURCES; i++)
            begin
                if (service_set[(first + i) % SOURCES])
                begin
                    id = 32'((first + i) % SOURCES);
                    break;
                end
            end
        end
        return id;
    endfunction

    function automatic req_item_t random_item();
        req_item_t item;
        int        pick;
        int        reg_pick;
        item = '0;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            item.kind    = KIND_SAMPLE;
            item.address = 22'($urandom_range(22'h3FFFFF));
        end
        else if (pick < 40)
        begin
            item.kind    = KIND_READ;
            item.address = ADDR_CLAIM;
        end
        else if (pick < 55)
        begin
            item.kind       = KIND_WRITE;
            item.address    = ADDR_CLAIM;
            item.write_data = completion_id();
        end
        else if (pick < 65)
        begin
            item.kind       = KIND_WRITE;
            item.address    = ADDR_PRIORITY + 22'(4 * $urandom_range(SOURCES - 1));
            item.write_data = ($urandom_range(5) == 0) ? $urandom : 32'($urandom_range(7));
        end
        else if (pick < 70)
        begin
            item.kind       = KIND_WRITE;
            item.address    = ADDR_ENABLE;
            item.write_data = $urandom | ($urandom_range(1) ? $urandom : 32'd0);
        end
        else if (pick < 74)
        begin
            item.kind       = KIND_WRITE;
            item.address    = ADDR_THRESHOLD;
            item.write_data = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(3));
        end
        else if (pick < 86)
        begin
            item.kind = KIND_READ;
            reg_pick  = $urandom_range(3);
            case (reg_pick)
                0: item.address = ADDR_PRIORITY + 22'(4 * $urandom_range(SOURCES - 1));
                1: item.address = ADDR_PENDING;
                2: item.address = ADDR_ENABLE;
                default: item.address = ADDR_THRESHOLD;
            endcase
        end
        else
        begin
            item.kind       = 2'($urandom_range(3));
            item.write_data = $urandom;
            case ($urandom_range(2))
                0: item.address = 22'($urandom_range(22'h3FFFFF));
                1: item.address = ADDR_CLAIM + 22'($urandom_range(3));
                default: item.address = ADDR_ENABLE + 22'($urandom_range(255));
            endcase
        end
        if ($urandom_range(19) == 0)
            item.source_levels = $urandom;
        else if ($urandom_range(2) == 0)
            item.source_levels = $urandom & $urandom & $urandom;
        return item;
    endfunction

    task automatic add_row(input kind_t kind, input logic [21:0] address,
                           input logic [31:0] write_data, input logic [31:0] levels,
                           input bit fixed, input logic [31:0] read_data, input logic irq);
        directed_row_t row;
        row.item.kind          = kind;
        row.item.address       = address;
        row.item.write_data    = write_data;
        row.item.source_levels = levels;
        row.fixed              = fixed;
        row.want.read_data     = read_data;
        row.want.hart_irq      = irq;
        directed_rows.push_back(row);
    endtask

    task automatic issue_transaction(input req_item_t item, input bit fixed,
                                     input rsp_item_t want);
        rsp_item_t predicted;
        request <= item;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_response(item);
        expected_responses.push_back(fixed ? want : predicted);
    endtask

    task automatic sender_gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_responses();
        while (expected_responses.size() != 0)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        for (int i = 0; i < SOURCES; i++)
            prio_table[i] = '0;
        pending_set     = '0;
        service_set     = '0;
        enable_set      = '0;
        threshold_level = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(KIND_READ,   ADDR_PRIORITY + 22'd4,   32'd0,        32'd0,        1, 32'd0, 0);
        add_row(KIND_READ,   ADDR_PENDING,            32'd0,        32'd0,        1, 32'd0, 0);
        add_row(KIND_WRITE,  ADDR_PRIORITY + 22'd4,   32'hFFFFFFFF, 32'd0,        1, 32'd0, 0);
        add_row(KIND_READ,   ADDR_PRIORITY + 22'd4,   32'd0,        32'd0,        1, 32'd7, 0);
        add_row(KIND_WRITE,  ADDR_PRIORITY,           32'd5,        32'd0,        1, 32'd0, 0);
        add_row(KIND_READ,   ADDR_PRIORITY,           32'd0,        32'd0,        1, 32'd0, 0);
        add_row(KIND_WRITE,  ADDR_PRIORITY + 22'd124, 32'd3,        32'd0,        0, 32'd0, 0);
        add_row(KIND_WRITE,  ADDR_ENABLE,             32'hFFFFFFFF, 32'd0,        1, 32'd0, 0);
        add_row(KIND_READ,   ADDR_ENABLE,             32'd0,        32'd0,        1, 32'hFFFFFFFE, 0);
        add_row(KIND_WRITE,  ADDR_THRESHOLD,          32'hFFFFFFFF, 32'd0,        1, 32'd0, 0);
        add_row(KIND_READ,   ADDR_THRESHOLD,          32'd0,        32'd0,        1, 32'd7, 0);
        add_row(KIND_SAMPLE, ADDR_PRIORITY,           32'd0,        32'hFFFFFFFF, 1, 32'd0, 0);
        add_row(KIND_READ,   ADDR_PENDING,            32'd0,        32'd0,        1, 32'hFFFFFFFE, 0);
        add_row(KIND_READ,   ADDR_CLAIM,              32'd0,        32'd0,        1, 32'd0, 0);
        add_row(KIND_WRITE,  ADDR_THRESHOLD,          32'd0,        32'd0,        0, 32'd0, 0);
        add_row(KIND_READ,   ADDR_CLAIM,              32'd0,        32'd0,        0, 32'd0, 0);
        add_row(KIND_READ,   ADDR_CLAIM,              32'd0,        32'd0,        0, 32'd0, 0);
        add_row(KIND_WRITE,  ADDR_CLAIM,              32'd1,        32'd0,        0, 32'd0, 0);
        add_row(KIND_WRITE,  ADDR_CLAIM,              32'd32,       32'd0,        0, 32'd0, 0);
        add_row(KIND_SPARE,  ADDR_CLAIM,              32'hFFFFFFFF, 32'hFFFFFFFF, 0, 32'd0, 0);
        add_row(KIND_READ,   ADDR_CLAIM + 22'd1,      32'd0,        32'd0,        0, 32'd0, 0);
        add_row(KIND_READ,   ADDR_ENABLE + ENABLE_STRIDE, 32'd0,    32'd0,        0, 32'd0, 0);
        add_row(KIND_READ,   ADDR_ENABLE + 22'd4,     32'd0,        32'd0,        0, 32'd0, 0);
        add_row(KIND_READ,   ADDR_THRESHOLD + CONTEXT_STRIDE, 32'd0, 32'd0,       0, 32'd0, 0);
        add_row(KIND_WRITE,  ADDR_PENDING,            32'd0,        32'd0,        0, 32'd0, 0);
        add_row(KIND_WRITE,  ADDR_ENABLE,             32'd0,        32'd0,        0, 32'd0, 0);
        add_row(KIND_WRITE,  ADDR_CLAIM,              32'd31,       32'd0,        0, 32'd0, 0);
        add_row(KIND_READ,   22'h3FFFFC,              32'hFFFFFFFF, 32'd0,        0, 32'd0, 0);

        foreach (directed_rows[i])
            issue_transaction(directed_rows[i].item, directed_rows[i].fixed,
                              directed_rows[i].want);
        drain_responses();

        for (int phase = 0; phase < 4; phase++)
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                issue_transaction(random_item(), 0, '0);
                sender_gap(idle_pct[phase]);
            end
            drain_responses();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin : check_response
        rsp_item_t want;
        if (rst_n && done)
        begin
            if (expected_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MISMATCH_SHOWN)
                    $display("response with no transaction waiting: read_data %h hart_irq %b",
                             response.read_data, response.hart_irq);
            end
            else
            begin
                want = expected_responses.pop_front();
                if (response.read_data !== want.read_data
                    || response.hart_irq !== want.hart_irq)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MISMATCH_SHOWN)
                        $display("mismatch: read_data exp %h got %h, hart_irq exp %b got %b",
                                 want.read_data, response.read_data,
                                 want.hart_irq, response.hart_irq);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

>>> files.f
+incdir+sv
sv/pic_pkg.sv
sv/platform_interrupt_controller.sv
sv/pic_checker.sv
dv/platform_interrupt_controller_tb.sv
